@@ hdl/utcsec_pkg.sv @@
// ----------------------------------------------------------------------------
// utcsec_pkg
// Types, constants and calendar tables for the UTC date to Unix seconds
// pipeline.
// ----------------------------------------------------------------------------
package utcsec_pkg;

    localparam logic [13:0] EPOCH_YEAR = 14'd1970;
    localparam logic [13:0] LAST_YEAR  = 14'd9999;
    localparam logic [4:0]  HOURS_PER_DAY = 5'd24;
    localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;

    // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT for x < 43690
    localparam logic [24:0] RECIP_25    = 25'd5243;
    localparam int          RECIP_SHIFT = 17;

    // leap days in years 1..1969
    localparam logic [11:0] LEAPS_BEFORE_EPOCH = 12'd477;

    localparam logic [21:0] DAYS_PER_YEAR = 22'd365;
    localparam logic [37:0] SECS_PER_DAY  = 38'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } date_t;

    typedef struct packed {
        logic [37:0] epoch_secs;
        logic        status;
    } result_t;

    // after the range checks and the divide-by-25 products
    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [12:0] year_off;
        logic [11:0] prev_q4;
        logic [24:0] prev_prod;
        logic [24:0] year_prod;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } yr_stage_t;

    // day count to Jan 1 known, leap flag settled, day checked
    typedef struct packed {
        logic        ok;
        logic        leap;
        logic [21:0] days_year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } day_stage_t;

    typedef struct packed {
        logic        ok;
        logic [21:0] days;
        logic [16:0] tod;
    } sec_stage_t;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // days before the first of the month, non-leap year
    function automatic logic [8:0] month_start(input logic [3:0] month);
        logic [8:0] d;
        unique case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

@@ hdl/utcsec_year.sv @@
// ----------------------------------------------------------------------------
// utcsec_year
// Stages 1 and 2: field range checks, leap rule and day count up to Jan 1.
// ----------------------------------------------------------------------------
module utcsec_year import utcsec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  date_t      in_date,
    output logic       out_valid,
    output day_stage_t out_stage
);

    logic       s1_valid_reg;
    yr_stage_t  s1_reg;
    yr_stage_t  s1_next;
    logic       s2_valid_reg;
    day_stage_t s2_reg;
    day_stage_t s2_next;

    logic [13:0] prev_year;
    logic [11:0] year_q4;
    logic [7:0]  prev_q100;
    logic [7:0]  year_q100;
    logic        div100;
    logic        leap;
    logic [11:0] leaps;

    always_comb
    begin
        prev_year = in_date.year - 14'd1;
        year_q4   = in_date.year[13:2];

        s1_next.ok = (in_date.year >= EPOCH_YEAR) && (in_date.year <= LAST_YEAR)
                  && (in_date.month != 4'd0) && (in_date.month <= MONTH_DEC)
                  && (in_date.day != 5'd0)
                  && (in_date.hour < HOURS_PER_DAY)
                  && (in_date.minute < MINS_PER_HOUR)
                  && (in_date.second < SECS_PER_MIN);
        s1_next.year      = in_date.year;
        s1_next.year_off  = 13'(in_date.year - EPOCH_YEAR);
        s1_next.prev_q4   = prev_year[13:2];
        // /100 as (/4) then (/25) by reciprocal
        s1_next.prev_prod = 25'(prev_year[13:2]) * RECIP_25;
        s1_next.year_prod = 25'(year_q4) * RECIP_25;
        s1_next.month     = in_date.month;
        s1_next.day       = in_date.day;
        s1_next.hour      = in_date.hour;
        s1_next.minute    = in_date.minute;
        s1_next.second    = in_date.second;
    end

    always_comb
    begin
        prev_q100 = 8'(s1_reg.prev_prod >> RECIP_SHIFT);
        year_q100 = 8'(s1_reg.year_prod >> RECIP_SHIFT);
        div100    = (14'(year_q100) * 14'd100) == s1_reg.year;
        leap      = (s1_reg.year[1:0] == 2'b00) && (!div100 || (year_q100[1:0] == 2'b00));
        // leap days in years 1970..year-1
        leaps     = s1_reg.prev_q4 - 12'(prev_q100) + 12'(prev_q100 >> 2) - LEAPS_BEFORE_EPOCH;

        s2_next.ok        = s1_reg.ok && (s1_reg.day <= month_len(s1_reg.month, leap));
        s2_next.leap      = leap;
        s2_next.days_year = 22'(s1_reg.year_off) * DAYS_PER_YEAR + 22'(leaps);
        s2_next.month     = s1_reg.month;
        s2_next.day       = s1_reg.day;
        s2_next.hour      = s1_reg.hour;
        s2_next.minute    = s1_reg.minute;
        s2_next.second    = s1_reg.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_stage = s2_reg;

endmodule

@@ hdl/utcsec_day.sv @@
// ----------------------------------------------------------------------------
// utcsec_day
// Stage 3: day of the epoch and second of the day.
// ----------------------------------------------------------------------------
module utcsec_day import utcsec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  day_stage_t in_stage,
    output logic       out_valid,
    output sec_stage_t out_stage
);

    logic       valid_reg;
    sec_stage_t stage_reg;
    sec_stage_t stage_next;

    always_comb
    begin
        stage_next.ok   = in_stage.ok;
        stage_next.days = in_stage.days_year
                        + 22'(month_start(in_stage.month))
                        + 22'(in_stage.leap && (in_stage.month > MONTH_FEB))
                        + 22'(in_stage.day) - 22'd1;
        stage_next.tod  = 17'(in_stage.hour) * SECS_PER_HOUR
                        + 17'(in_stage.minute) * 17'd60
                        + 17'(in_stage.second);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

@@ hdl/utcsec_secs.sv @@
// ----------------------------------------------------------------------------
// utcsec_secs
// Stage 4: days times 86400 plus second of day, zeroed on a bad date.
// ----------------------------------------------------------------------------
module utcsec_secs import utcsec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  sec_stage_t in_stage,
    output logic       out_valid,
    output result_t    out_data
);

    logic    valid_reg;
    result_t result_reg;
    result_t result_next;

    always_comb
    begin
        result_next.status     = !in_stage.ok;
        result_next.epoch_secs = in_stage.ok
                               ? 38'(in_stage.days) * SECS_PER_DAY + 38'(in_stage.tod)
                               : 38'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = result_reg;

endmodule

@@ hdl/utc_datetime_to_unix_seconds.sv @@
// ----------------------------------------------------------------------------
// utc_datetime_to_unix_seconds
// Each accepted date passes the year, day and seconds stages in turn to its done beat.
// Throughput: one date per cycle; busy stays low, the four-stage pipeline
// never stalls and results go out in input order.
// Reset clears the stage valid bits only; nothing is in flight afterwards.
// ----------------------------------------------------------------------------
module utc_datetime_to_unix_seconds import utcsec_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  date_t   item,
    output logic    done,
    output result_t result
);

    logic       yr_valid;
    day_stage_t yr_stage;
    logic       day_valid;
    sec_stage_t day_stage;

    assign busy = 1'b0;

    utcsec_year u_year (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_date   (item),
        .out_valid (yr_valid),
        .out_stage (yr_stage)
    );

    utcsec_day u_day (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (yr_valid),
        .in_stage  (yr_stage),
        .out_valid (day_valid),
        .out_stage (day_stage)
    );

    utcsec_secs u_secs (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (day_valid),
        .in_stage  (day_stage),
        .out_valid (done),
        .out_data  (result)
    );

    // every accepted beat comes out as a done beat at the end of the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result beat missing four cycles after accept");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result beat without an accepted input");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (result.epoch_secs == 38'd0))
        else $error("invalid date with nonzero seconds");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.status) |-> (result.epoch_secs <= 38'd253402300799))
        else $error("seconds beyond last supported date");

endmodule
